FILE: hw/rtl/sdcd_pkg.sv
// ----------------------------------------------------------------------------
// Serial drive command decoder package
// Character codes, frame limits, register indexes and the structs that pass
// between the decoder and the top level.
// ----------------------------------------------------------------------------
package sdcd_pkg;

  // Frame characters
  localparam logic [7:0] CharOpen  = 8'h5B;  // '['
  localparam logic [7:0] CharClose = 8'h5D;  // ']'
  localparam logic [7:0] CharZero  = 8'h30;  // '0'

  // Longest frame, counted from the opening bracket
  localparam int unsigned FrameMax = 10;
  localparam int unsigned IdxW     = $clog2(FrameMax + 1);

  // The frame counter runs from zero up to this value and then wraps
  localparam logic [15:0] FrameWrap = 16'd60000;

  // Register reset values
  localparam logic [5:0] SpeedLimitReset   = 6'd50;
  localparam logic [7:0] TimeoutTicksReset = 8'd100;

  // Configuration register indexes
  typedef enum logic [0:0] {
    CfgSpeedLimit   = 1'b0,
    CfgTimeoutTicks = 1'b1
  } cfg_reg_e;

  // Direction command codes
  typedef enum logic [7:0] {
    DirStop      = 8'h30,
    DirSpinRight = 8'h31,
    DirVeerRight = 8'h32,
    DirForward   = 8'h33,
    DirBackRight = 8'h34,
    DirSpinLeft  = 8'h35,
    DirVeerLeft  = 8'h36,
    DirBackward  = 8'h37,
    DirBackLeft  = 8'h38
  } dir_cmd_e;

  // Speed command codes
  localparam logic [7:0] SpeedUp   = 8'h31;  // '1'
  localparam logic [7:0] SpeedDown = 8'h32;  // '2'

  // Request to the frame decoder: captured commands and current state
  typedef struct packed {
    logic [7:0]        speed_cmd;
    logic [7:0]        direction_cmd;
    logic [5:0]        speed_now;
    logic [5:0]        speed_limit;
    logic signed [6:0] left_goal;
    logic signed [6:0] right_goal;
  } dec_req_t;

  // Decoder answer: the state after the frame has been applied
  typedef struct packed {
    logic [5:0]        speed_now;
    logic signed [6:0] left_goal;
    logic signed [6:0] right_goal;
  } dec_rsp_t;

endpackage

FILE: hw/rtl/sdcd_if.sv
// ----------------------------------------------------------------------------
// Serial drive command decoder channels
// Input item, result item and configuration write channels, each with a
// valid/ready handshake.
// ----------------------------------------------------------------------------

// Input item: a received byte or a timer tick
interface sdcd_in_if;
  logic       valid;
  logic       ready;
  logic       action;
  logic [7:0] byte_value;

  modport source (output valid, action, byte_value, input ready);
  modport sink   (input valid, action, byte_value, output ready);
endinterface

// Result item: wheel targets and status
interface sdcd_out_if;
  logic              valid;
  logic              ready;
  logic signed [6:0] left_target;
  logic signed [6:0] right_target;
  logic [5:0]        speed_level;
  logic              frame_done;
  logic              timeout_fired;
  logic              collecting;

  modport source (output valid, left_target, right_target, speed_level, frame_done,
                  timeout_fired, collecting, input ready);
  modport sink   (input valid, left_target, right_target, speed_level, frame_done,
                  timeout_fired, collecting, output ready);
endinterface

// Configuration write channel
interface sdcd_cfg_if;
  logic       valid;
  logic       ready;
  logic [0:0] index;
  logic [7:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

FILE: hw/rtl/sdcd_decode.sv
// ----------------------------------------------------------------------------
// Serial drive command frame decoder
// Applies the speed command and selects the left and right wheel targets
// from the direction command.
// ----------------------------------------------------------------------------
module sdcd_decode (
  input  sdcd_pkg::dec_req_t req_i,
  output sdcd_pkg::dec_rsp_t rsp_o
);
  import sdcd_pkg::*;

  logic [5:0]        speed;
  logic signed [6:0] full_pos;
  logic signed [6:0] full_neg;
  logic signed [6:0] half_pos;
  logic signed [6:0] half_neg;

  // Saturating speed step
  always_comb begin
    speed = req_i.speed_now;
    if (req_i.speed_cmd == SpeedUp) begin
      if (req_i.speed_now < req_i.speed_limit) begin
        speed = req_i.speed_now + 6'd1;
      end
    end else if (req_i.speed_cmd == SpeedDown) begin
      if (req_i.speed_now != 6'd0) begin
        speed = req_i.speed_now - 6'd1;
      end
    end
  end

  // Speed is non-negative, so halving by a shift truncates toward zero.
  assign full_pos = {1'b0, speed};
  assign full_neg = -full_pos;
  assign half_pos = {2'b00, speed[5:1]};
  assign half_neg = -half_pos;

  always_comb begin
    rsp_o.speed_now  = speed;
    rsp_o.left_goal  = req_i.left_goal;
    rsp_o.right_goal = req_i.right_goal;
    unique case (req_i.direction_cmd)
      DirStop: begin
        rsp_o.left_goal  = 7'sd0;
        rsp_o.right_goal = 7'sd0;
      end
      DirSpinRight: begin
        rsp_o.left_goal  = full_pos;
        rsp_o.right_goal = full_neg;
      end
      DirVeerRight: begin
        rsp_o.left_goal  = full_pos;
        rsp_o.right_goal = half_neg;
      end
      DirForward: begin
        rsp_o.left_goal  = full_pos;
        rsp_o.right_goal = full_pos;
      end
      DirBackRight: begin
        rsp_o.left_goal  = full_neg;
        rsp_o.right_goal = half_pos;
      end
      DirSpinLeft: begin
        rsp_o.left_goal  = full_neg;
        rsp_o.right_goal = full_pos;
      end
      DirVeerLeft: begin
        rsp_o.left_goal  = half_neg;
        rsp_o.right_goal = full_pos;
      end
      DirBackward: begin
        rsp_o.left_goal  = full_neg;
        rsp_o.right_goal = full_neg;
      end
      DirBackLeft: begin
        rsp_o.left_goal  = half_pos;
        rsp_o.right_goal = full_neg;
      end
      default: begin
        rsp_o.left_goal  = req_i.left_goal;
        rsp_o.right_goal = req_i.right_goal;
      end
    endcase
  end

endmodule

FILE: hw/rtl/serial_drive_command_decoder.sv
// ----------------------------------------------------------------------------
// Serial drive command decoder
// Frames received bytes into drive commands, keeps the speed level and the
// wheel targets, and zeroes the targets when frames stop arriving.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Carries
//   in_i      sink       action (byte or tick), byte_value
//   out_o     source     left_target, right_target, speed_level, frame_done,
//                        timeout_fired, collecting
//   cfg_i     sink       index (0 speed_limit, 1 timeout_ticks), data
//
// The frame state, the watchdog and the result register are all updated at
// the edge that accepts an item, so one item can be accepted in every cycle.
// The result register alone sets the pace: a new item is taken whenever it
// is empty or being emptied in the same cycle. A stall on the output side
// holds the result and stops input. Reset clears the valid flag and all
// frame, drive and watchdog state and loads the register reset values;
// configuration writes are always accepted.
//
module serial_drive_command_decoder (
  input logic       clk_i,
  input logic       rst_ni,
  sdcd_in_if.sink   in_i,
  sdcd_out_if.source out_o,
  sdcd_cfg_if.sink  cfg_i
);
  import sdcd_pkg::*;

  // Configuration registers
  logic [5:0] speed_limit_q;
  logic [7:0] timeout_ticks_q;

  // Frame collection state
  logic            in_frame_q,      in_frame_d;
  logic [IdxW-1:0] byte_index_q,    byte_index_d;
  logic [7:0]      speed_cmd_q,     speed_cmd_d;
  logic [7:0]      direction_cmd_q, direction_cmd_d;

  // Drive state
  logic [5:0]        speed_now_q,  speed_now_d;
  logic signed [6:0] left_goal_q,  left_goal_d;
  logic signed [6:0] right_goal_q, right_goal_d;

  // Watchdog state
  logic [7:0]  tick_count_q,       tick_count_d;
  logic [15:0] frame_count_q,      frame_count_d;
  logic [15:0] frame_count_seen_q, frame_count_seen_d;

  // Result register
  logic              out_valid_q;
  logic signed [6:0] left_target_q;
  logic signed [6:0] right_target_q;
  logic [5:0]        speed_level_q;
  logic              frame_done_q,    frame_done_d;
  logic              timeout_fired_q, timeout_fired_d;
  logic              collecting_q;

  logic     in_ready;
  logic     in_accept;
  dec_req_t dec_req;
  dec_rsp_t dec_rsp;

  assign in_ready  = !out_valid_q || out_o.ready;
  assign in_accept = in_i.valid && in_ready;
  assign in_i.ready  = in_ready;
  assign cfg_i.ready = 1'b1;

  // The decoder always looks at the captured commands; its answer is used
  // only when the current item is a closing bracket.
  assign dec_req.speed_cmd     = speed_cmd_q;
  assign dec_req.direction_cmd = direction_cmd_q;
  assign dec_req.speed_now     = speed_now_q;
  assign dec_req.speed_limit   = speed_limit_q;
  assign dec_req.left_goal     = left_goal_q;
  assign dec_req.right_goal    = right_goal_q;

  sdcd_decode u_decode (
    .req_i (dec_req),
    .rsp_o (dec_rsp)
  );

  // Next state for one item
  always_comb begin
    logic [IdxW-1:0] idx_next;

    in_frame_d         = in_frame_q;
    byte_index_d       = byte_index_q;
    speed_cmd_d        = speed_cmd_q;
    direction_cmd_d    = direction_cmd_q;
    speed_now_d        = speed_now_q;
    left_goal_d        = left_goal_q;
    right_goal_d       = right_goal_q;
    tick_count_d       = tick_count_q;
    frame_count_d      = frame_count_q;
    frame_count_seen_d = frame_count_seen_q;
    frame_done_d       = 1'b0;
    timeout_fired_d    = 1'b0;
    idx_next           = '0;

    if (in_i.action) begin
      // Timer tick: the watchdog checks once every timeout_ticks + 1 ticks
      // whether the frame counter has moved since the last check.
      tick_count_d = tick_count_q + 8'd1;
      if (tick_count_q == timeout_ticks_q) begin
        tick_count_d = 8'd0;
        if (frame_count_seen_q == frame_count_q) begin
          left_goal_d     = 7'sd0;
          right_goal_d    = 7'sd0;
          timeout_fired_d = 1'b1;
        end else begin
          frame_count_seen_d = frame_count_q;
        end
      end
    end else if (in_i.byte_value == CharClose) begin
      // A closing bracket decodes even outside a frame; the cleared
      // commands then leave speed and targets as they are.
      frame_count_d   = (frame_count_q == FrameWrap) ? 16'd0 : frame_count_q + 16'd1;
      speed_now_d     = dec_rsp.speed_now;
      left_goal_d     = dec_rsp.left_goal;
      right_goal_d    = dec_rsp.right_goal;
      in_frame_d      = 1'b0;
      byte_index_d    = '0;
      speed_cmd_d     = 8'd0;
      direction_cmd_d = 8'd0;
      frame_done_d    = 1'b1;
    end else begin
      // An opening bracket always starts afresh at position zero.
      if (in_i.byte_value == CharOpen) begin
        in_frame_d      = 1'b1;
        byte_index_d    = '0;
        speed_cmd_d     = 8'd0;
        direction_cmd_d = 8'd0;
      end
      if (in_frame_d) begin
        if (byte_index_d == IdxW'(1)) begin
          speed_cmd_d = in_i.byte_value;
        end else if (byte_index_d == IdxW'(2)) begin
          direction_cmd_d = in_i.byte_value;
        end
        idx_next     = byte_index_d + IdxW'(1);
        byte_index_d = idx_next;
        // Too long a frame is dropped.
        if (idx_next >= IdxW'(FrameMax)) begin
          in_frame_d      = 1'b0;
          byte_index_d    = '0;
          speed_cmd_d     = 8'd0;
          direction_cmd_d = 8'd0;
        end
      end
    end
  end

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      speed_limit_q   <= SpeedLimitReset;
      timeout_ticks_q <= TimeoutTicksReset;
    end else if (cfg_i.valid) begin
      unique case (cfg_reg_e'(cfg_i.index))
        CfgSpeedLimit:   speed_limit_q   <= cfg_i.data[5:0];
        CfgTimeoutTicks: timeout_ticks_q <= cfg_i.data;
        default: ;
      endcase
    end
  end

  // Block state, updated once per accepted item
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_frame_q         <= 1'b0;
      byte_index_q       <= '0;
      speed_cmd_q        <= 8'd0;
      direction_cmd_q    <= 8'd0;
      speed_now_q        <= 6'd0;
      left_goal_q        <= 7'sd0;
      right_goal_q       <= 7'sd0;
      tick_count_q       <= 8'd0;
      frame_count_q      <= 16'd0;
      frame_count_seen_q <= 16'd0;
    end else if (in_accept) begin
      in_frame_q         <= in_frame_d;
      byte_index_q       <= byte_index_d;
      speed_cmd_q        <= speed_cmd_d;
      direction_cmd_q    <= direction_cmd_d;
      speed_now_q        <= speed_now_d;
      left_goal_q        <= left_goal_d;
      right_goal_q       <= right_goal_d;
      tick_count_q       <= tick_count_d;
      frame_count_q      <= frame_count_d;
      frame_count_seen_q <= frame_count_seen_d;
    end
  end

  // Result register valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= in_accept || (out_valid_q && !out_o.ready);
    end
  end

  // Result payload
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      left_target_q   <= left_goal_d;
      right_target_q  <= right_goal_d;
      speed_level_q   <= speed_now_d;
      frame_done_q    <= frame_done_d;
      timeout_fired_q <= timeout_fired_d;
      collecting_q    <= in_frame_d;
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.left_target   = left_target_q;
  assign out_o.right_target  = right_target_q;
  assign out_o.speed_level   = speed_level_q;
  assign out_o.frame_done    = frame_done_q;
  assign out_o.timeout_fired = timeout_fired_q;
  assign out_o.collecting    = collecting_q;

endmodule

FILE: sim/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Serial drive command decoder testbench
// Drives received bytes and timer ticks into the decoder, predicts every
// result item from a behavioural copy of the frame logic, the speed level
// and the watchdog, and compares each result field by field. The run passes
// through several register settings and through phases of random idling
// on both sides of the block.
// ----------------------------------------------------------------------------
module testbench;
  import sdcd_pkg::*;

  localparam int unsigned CycleLimit = 500000;

  // One input item as queued for the driver
  typedef struct packed {
    logic       is_tick;
    logic [7:0] rx;
  } rx_event_t;

  // One result item as the block should deliver it
  typedef struct packed {
    logic signed [6:0] left_target;
    logic signed [6:0] right_target;
    logic [5:0]        speed_level;
    logic              frame_done;
    logic              timeout_fired;
    logic              collecting;
  } drive_result_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  sdcd_in_if  in_if ();
  sdcd_out_if out_if ();
  sdcd_cfg_if cfg_if ();

  serial_drive_command_decoder dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if),
    .cfg_i  (cfg_if)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Items waiting for the driver, and results waiting for the block
  rx_event_t     pending_events[$];
  drive_result_t expected_results[$];

  int unsigned send_idle_pct = 18;
  int unsigned take_idle_pct = 71;
  int unsigned fail_count    = 0;
  int unsigned cycle_count   = 0;

  // --------------------------------------------------------------------------
  // Behavioural copy of the decoder. Register values as last written, then
  // the frame collector, the speed level, the wheel goals and the watchdog.
  // --------------------------------------------------------------------------
  logic [5:0]        limit_now       = SpeedLimitReset;
  logic [7:0]        timeout_now     = TimeoutTicksReset;
  logic              frame_open      = 1'b0;
  int unsigned       frame_pos       = 0;
  logic [7:0]        held_speed_cmd  = '0;
  logic [7:0]        held_dir_cmd    = '0;
  logic [5:0]        level           = '0;
  logic signed [6:0] left_goal       = '0;
  logic signed [6:0] right_goal      = '0;
  logic [7:0]        tick_cnt        = '0;
  logic [15:0]       frames_decoded  = '0;
  logic [15:0]       frames_at_check = '0;

  // Leaving a frame for any reason forgets the position and both commands.
  function automatic void drop_frame();
    frame_open     = 1'b0;
    frame_pos      = 0;
    held_speed_cmd = '0;
    held_dir_cmd   = '0;
  endfunction

  function automatic drive_result_t decode_event(input logic is_tick, input logic [7:0] rx);
    drive_result_t     res;
    logic signed [6:0] full;
    logic signed [6:0] half;
    logic [7:0]        prior;
    res = '0;
    if (is_tick) begin
      // The check falls on the tick at which the count equals the period
      // register before it is incremented; the 8-bit count may wrap first
      // when the register has been lowered below it.
      prior    = tick_cnt;
      tick_cnt = tick_cnt + 8'd1;
      if (prior == timeout_now) begin
        tick_cnt = '0;
        if (frames_at_check == frames_decoded) begin
          left_goal         = '0;
          right_goal        = '0;
          res.timeout_fired = 1'b1;
        end else begin
          frames_at_check = frames_decoded;
        end
      end
    end else if (rx == CharClose) begin
      // A close is decoded even outside a frame, with both commands zero.
      frames_decoded = (frames_decoded == FrameWrap) ? 16'd0 : frames_decoded + 16'd1;
      if (held_speed_cmd == SpeedUp) begin
        if (level < limit_now) level = level + 6'd1;
      end else if (held_speed_cmd == SpeedDown) begin
        if (level != 6'd0) level = level - 6'd1;
      end
      full = $signed({1'b0, level});
      half = $signed({2'b00, level[5:1]});
      case (held_dir_cmd)
        DirStop: begin
          left_goal  = '0;
          right_goal = '0;
        end
        DirSpinRight: begin
          left_goal  = full;
          right_goal = -full;
        end
        DirVeerRight: begin
          left_goal  = full;
          right_goal = -half;
        end
        DirForward: begin
          left_goal  = full;
          right_goal = full;
        end
        DirBackRight: begin
          left_goal  = -full;
          right_goal = half;
        end
        DirSpinLeft: begin
          left_goal  = -full;
          right_goal = full;
        end
        DirVeerLeft: begin
          left_goal  = -half;
          right_goal = full;
        end
        DirBackward: begin
          left_goal  = -full;
          right_goal = -full;
        end
        DirBackLeft: begin
          left_goal  = half;
          right_goal = -full;
        end
        default: begin
        end
      endcase
      drop_frame();
      res.frame_done = 1'b1;
    end else begin
      if (rx == CharOpen) begin
        drop_frame();
        frame_open = 1'b1;
      end
      if (frame_open) begin
        if (frame_pos == 1) begin
          held_speed_cmd = rx;
        end else if (frame_pos == 2) begin
          held_dir_cmd = rx;
        end
        frame_pos++;
        if (frame_pos >= FrameMax) drop_frame();
      end
    end
    res.left_target  = left_goal;
    res.right_target = right_goal;
    res.speed_level  = level;
    res.collecting   = frame_open;
    return res;
  endfunction

  // --------------------------------------------------------------------------
  // Driver: presents queued items one by one and predicts each item at the
  // edge that accepts it. A waiting item is held until it is taken.
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin : drive_items
    rx_event_t ev;
    if (!rst_ni) begin
      in_if.valid <= 1'b0;
    end else begin
      if (in_if.valid && in_if.ready) begin
        expected_results.push_back(decode_event(in_if.action, in_if.byte_value));
      end
      if (!in_if.valid || in_if.ready) begin
        if (pending_events.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          ev = pending_events.pop_front();
          in_if.valid      <= 1'b1;
          in_if.action     <= ev.is_tick;
          in_if.byte_value <= ev.rx;
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: stalls the result channel at random and compares each result
  // item with the oldest prediction.
  // --------------------------------------------------------------------------
  task automatic check_field(input string name, input logic signed [7:0] want,
                             input logic signed [7:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk_i) begin : check_results
    drive_result_t want;
    out_if.ready <= ($urandom_range(99) >= take_idle_pct);
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (expected_results.size() == 0) begin
        $error("result item arrived with no item outstanding");
        fail_count++;
      end else begin
        want = expected_results.pop_front();
        check_field("left_target", want.left_target, out_if.left_target);
        check_field("right_target", want.right_target, out_if.right_target);
        check_field("speed_level", want.speed_level, out_if.speed_level);
        check_field("frame_done", want.frame_done, out_if.frame_done);
        check_field("timeout_fired", want.timeout_fired, out_if.timeout_fired);
        check_field("collecting", want.collecting, out_if.collecting);
      end
    end
  end

  // A run that hangs is a failure in its own right.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  function automatic void queue_byte(input logic [7:0] b);
    pending_events.push_back('{1'b0, b});
  endfunction

  // The byte lines are random on a tick, as the block ignores them.
  function automatic void queue_tick();
    pending_events.push_back('{1'b1, 8'($urandom_range(255))});
  endfunction

  // A random byte that neither opens nor closes a frame
  function automatic logic [7:0] plain_byte();
    logic [7:0] b;
    do b = 8'($urandom_range(255)); while (b == CharOpen || b == CharClose);
    return b;
  endfunction

  // Mostly well-formed frames with random commands, so that the speed level
  // and the wheel goals move; the rest is ticks, loose bytes, closes outside
  // a frame and frames that run past the buffer or never close.
  task automatic queue_random(input int unsigned count);
    int unsigned start;
    int unsigned pick;
    int unsigned extra;
    start = pending_events.size();
    while (pending_events.size() - start < count) begin
      pick = $urandom_range(99);
      if (pick < 60) begin
        queue_byte(CharOpen);
        if ($urandom_range(99) < 88) begin
          queue_byte(($urandom_range(99) < 60) ? SpeedUp : SpeedDown);
        end else begin
          queue_byte(8'($urandom_range(255)));
        end
        if ($urandom_range(99) < 88) begin
          queue_byte(DirStop + 8'($urandom_range(8)));
        end else begin
          queue_byte(8'($urandom_range(255)));
        end
        if ($urandom_range(99) < 15) begin
          extra = $urandom_range(1, 6);
          repeat (extra) queue_byte(plain_byte());
        end
        queue_byte(CharClose);
      end else if (pick < 75) begin
        extra = $urandom_range(1, 4);
        repeat (extra) queue_tick();
      end else if (pick < 85) begin
        queue_byte(8'($urandom_range(255)));
      end else if (pick < 93) begin
        queue_byte(CharOpen);
        extra = $urandom_range(1, 12);
        repeat (extra) queue_byte(plain_byte());
        if ($urandom_range(1)) queue_byte(CharClose);
      end else begin
        queue_byte(CharClose);
      end
    end
  endtask

  // Waits until the block holds no item and no result is outstanding,
  // then waits further for it to settle.
  task automatic wait_idle();
    do @(negedge clk_i);
    while (pending_events.size() != 0 || in_if.valid || expected_results.size() != 0);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_register(input cfg_reg_e which, input logic [7:0] value);
    @(posedge clk_i);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= which;
    cfg_if.data  <= value;
    do @(posedge clk_i); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    if (which == CfgSpeedLimit) begin
      limit_now = value[5:0];
    end else begin
      timeout_now = value;
    end
  endtask

  // One phase: new register values, new idling, then random items in two
  // halves with a full drain in between.
  task automatic run_phase(input logic [5:0] limit, input logic [7:0] period,
                           input int unsigned send_pct, input int unsigned take_pct,
                           input int unsigned count, input int unsigned tick_burst);
    wait_idle();
    // The unused upper bits of the speed limit data are set at random.
    write_register(CfgSpeedLimit, {2'($urandom_range(3)), limit});
    write_register(CfgTimeoutTicks, period);
    @(negedge clk_i);
    send_idle_pct = send_pct;
    take_idle_pct = take_pct;
    repeat (tick_burst) queue_tick();
    queue_random(count / 2);
    wait_idle();
    queue_random(count - count / 2);
  endtask

  initial begin
    rst_ni           = 1'b0;
    in_if.valid      = 1'b0;
    in_if.action     = 1'b0;
    in_if.byte_value = '0;
    out_if.ready     = 1'b0;
    cfg_if.valid     = 1'b0;
    cfg_if.index     = CfgSpeedLimit;
    cfg_if.data      = '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed items with the reset register values. A close with no frame
    // open, speed up with forward and with a half speed direction, a second
    // open inside a frame that restarts it, and a frame that overflows the
    // buffer with the extreme byte values.
    queue_byte(CharClose);
    queue_byte(CharOpen);
    queue_byte(SpeedUp);
    queue_byte(DirForward);
    queue_byte(CharClose);
    queue_byte(CharOpen);
    queue_byte(SpeedUp);
    queue_byte(DirBackLeft);
    queue_byte(CharClose);
    queue_byte(CharOpen);
    queue_byte(DirBackward);
    queue_byte(CharOpen);
    queue_byte(SpeedDown);
    queue_byte(DirSpinLeft);
    queue_byte(CharClose);
    queue_byte(CharOpen);
    for (int i = 0; i < FrameMax - 1; i++) queue_byte((i % 2 == 0) ? 8'h00 : 8'hFF);
    queue_tick();

    // Highest limit with a watchdog check on every tick.
    run_phase(6'd63, 8'd0, 18, 71, 160, 0);
    // Limit dropped below the level reached, longest period; the burst of
    // ticks runs the tick counter through its full range.
    run_phase(6'd0, 8'd255, 18, 71, 160, 260);
    // Now the sender idles most and the receiver rarely.
    run_phase(6'd5, 8'd3, 71, 18, 160, 0);
    run_phase(6'd63, 8'd7, 71, 18, 160, 0);
    // Neither side idles.
    run_phase(6'd50, 8'd1, 0, 0, 160, 0);

    wait_idle();
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

FILE: files.f
hw/rtl/sdcd_pkg.sv
hw/rtl/sdcd_if.sv
hw/rtl/sdcd_decode.sv
hw/rtl/serial_drive_command_decoder.sv
sim/testbench.sv
